// ----- rtl/astg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR sine tone generator package
// Widths, codes, control structs and the sine and root lookup tables.
// ----------------------------------------------------------------------------
package astg_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int ENV_TABLE_BITS  = 10;
    localparam int LENGTH_BITS     = 20;

    localparam int PHASE_W    = 32;
    localparam int SAMPLE_W   = 16;
    localparam int SEG_W      = 2;
    localparam int AMP_W      = 15;
    localparam int ENV_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    localparam int I10_W      = LENGTH_BITS + 4;
    localparam int DEN_W      = LENGTH_BITS + 2;
    localparam int ENV_IDX_W  = ENV_TABLE_BITS + 1;
    localparam int DIV_CNT_W  = $clog2(ENV_TABLE_BITS);

    localparam int SINE_DEPTH = 1 << SINE_TABLE_BITS;
    localparam int ENV_DEPTH  = 1 << ENV_TABLE_BITS;
    localparam int ROOT_DEPTH = ENV_DEPTH + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_LENGTH = 1'd1;

    localparam logic [AMP_W-1:0]       AMP_RESET         = 15'd6000;
    localparam logic [LENGTH_BITS-1:0] NOTE_LENGTH_RESET = LENGTH_BITS'(44100);
    localparam logic [LENGTH_BITS-1:0] MIN_LENGTH        = LENGTH_BITS'(4);

    localparam logic [ENV_W-1:0] ONE_Q15         = 16'd32768;
    localparam logic [ENV_W-1:0] SUSTAIN_Q15     = 16'd22938;
    localparam logic [AMP_W-1:0] DECAY_DEPTH_Q15 = 15'd9830;
    localparam logic [AMP_W-1:0] SUSTAIN_COEF    = 15'd22938;
    localparam logic [63:0]      PIHALF_Q30      = 64'd1686629713;

    typedef enum logic [SEG_W-1:0] {
        SEG_ATTACK  = 2'd0,
        SEG_DECAY   = 2'd1,
        SEG_SUSTAIN = 2'd2,
        SEG_RELEASE = 2'd3
    } t_seg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCALE,
        ST_SEG,
        ST_PREP,
        ST_DIV,
        ST_ROM,
        ST_ENV,
        ST_GAIN,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic setup;
        logic scale;
        logic seg;
        logic prep;
        logic div_step;
        logic rom;
        logic env;
        logic gain;
        logic mul;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic will_run;
        logic out_free;
    } t_dp_sts;

    typedef logic signed [SAMPLE_W-1:0] t_sine_rom [SINE_DEPTH];
    typedef logic [ENV_W-1:0]           t_root_rom [ROOT_DEPTH];

    function automatic logic [63:0] pow_q30(input logic [63:0] y, input int n);
        logic [63:0] t;
        t = y << 15;
        for (int r = 1; r < n; r++) begin
            t = (t * y) >> 15;
        end
        return t;
    endfunction

    function automatic logic [ENV_W-1:0] root_entry(input int k, input int n);
        logic [63:0] target;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        target = 64'(k) << (30 - ENV_TABLE_BITS);
        lo     = 64'd0;
        hi     = 64'(ONE_Q15);
        for (int it = 0; it < 17; it++) begin
            if (lo < hi) begin
                mid = (lo + hi + 64'd1) >> 1;
                if (pow_q30(mid, n) <= target) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return lo[ENV_W-1:0];
    endfunction

    function automatic logic [15:0] quarter_sine(input int m);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        q;
        x    = (64'(m) * PIHALF_Q30) >> (SINE_TABLE_BITS - 2);
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= 5; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            unique case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                default: term = term / 64'd110;
            endcase
            if (n % 2 == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        q = (unsigned'(sum) + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[15:0];
    endfunction

    function automatic t_sine_rom build_sine();
        t_sine_rom   t;
        int          j;
        int          m;
        logic [15:0] v;
        for (int k = 0; k < SINE_DEPTH; k++) begin
            j = k & (SINE_DEPTH / 2 - 1);
            m = (j <= SINE_DEPTH / 4) ? j : SINE_DEPTH / 2 - j;
            v = quarter_sine(m);
            t[k] = (k >= SINE_DEPTH / 2) ? -signed'(v) : signed'(v);
        end
        return t;
    endfunction

    function automatic t_root_rom build_root(input int n);
        t_root_rom t;
        for (int k = 0; k < ROOT_DEPTH; k++) begin
            t[k] = root_entry(k, n);
        end
        return t;
    endfunction

    localparam t_sine_rom SINE_ROM   = build_sine();
    localparam t_root_rom ROOT10_ROM = build_root(10);
    localparam t_root_rom ROOT5_ROM  = build_root(5);

endpackage

// ----- rtl/astg_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR sine tone generator controller
// Sequences one request through setup, scaling, segment select, division,
// root lookup, envelope, gain, multiply and output load.
module astg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  astg_pkg::t_dp_sts i_sts,
    output astg_pkg::t_dp_cmd o_cmd
);
    import astg_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic [DIV_CNT_W-1:0]  n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_div_cnt  = r_div_cnt;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.will_run) begin
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_SEG;
            end
            ST_SEG: begin
                o_cmd.seg = 1'b1;
                n_state   = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_div_cnt  = '0;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == DIV_CNT_W'(ENV_TABLE_BITS - 1)) begin
                    n_div_cnt = '0;
                    n_state   = ST_ROM;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            ST_ROM: begin
                o_cmd.rom = 1'b1;
                n_state   = ST_ENV;
            end
            ST_ENV: begin
                o_cmd.env = 1'b1;
                n_state   = ST_GAIN;
            end
            ST_GAIN: begin
                o_cmd.gain = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/astg_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR sine tone generator datapath
// Note state, config registers, segment divider, envelope and sample math.
// ----------------------------------------------------------------------------
module astg_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [astg_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [astg_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_start_note,
    input  logic [astg_pkg::PHASE_W-1:0]           i_phase_step,
    input  logic                                   i_out_stall,
    input  astg_pkg::t_dp_cmd                      i_cmd,
    output astg_pkg::t_dp_sts                      o_sts,
    output logic                                   o_out_valid,
    output logic signed [astg_pkg::SAMPLE_W-1:0]   o_sample,
    output logic [astg_pkg::SEG_W-1:0]             o_segment,
    output logic                                   o_last
);
    import astg_pkg::*;

    // config and note state
    logic [AMP_W-1:0]          r_amplitude;
    logic [LENGTH_BITS-1:0]    r_note_length;
    logic                      r_active;
    logic [LENGTH_BITS-1:0]    r_index;
    logic [PHASE_W-1:0]        r_phase;
    logic [PHASE_W-1:0]        r_held;
    logic                      r_out_valid;

    // per-request working registers
    logic [LENGTH_BITS-1:0]    r_len;
    logic [LENGTH_BITS-1:0]    r_i;
    logic                      r_last;
    logic [SINE_TABLE_BITS-1:0] r_sin_idx;
    logic signed [SAMPLE_W-1:0] r_sin;
    logic [I10_W-1:0]          r_i10;
    logic [I10_W-1:0]          r_l2;
    logic [I10_W-1:0]          r_l3;
    logic [I10_W-1:0]          r_l8;
    t_seg                      r_seg;
    logic [DEN_W-1:0]          r_rem;
    logic [DEN_W-1:0]          r_den;
    logic [ENV_TABLE_BITS-1:0] r_quo;
    logic [ENV_W-1:0]          r_r10;
    logic [ENV_W-1:0]          r_r5;
    logic [ENV_W-1:0]          r_env;
    logic [AMP_W-1:0]          r_gain;
    logic signed [SAMPLE_W-1:0] r_smp;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    t_seg                      r_out_seg;
    logic                      r_out_last;

    logic [LENGTH_BITS-1:0]    w_len;
    logic [LENGTH_BITS-1:0]    w_len_m1;
    logic [DEN_W:0]            w_rem2;
    logic                      w_qbit;
    logic [ENV_IDX_W-1:0]      w_r5_idx;
    logic [AMP_W-1:0]          w_coef;
    logic [AMP_W+ENV_W-1:0]    w_env_prod;
    logic [AMP_W+ENV_W-1:0]    w_gain_prod;
    logic [SAMPLE_W-1:0]       w_sin_abs;
    logic [2*AMP_W-1:0]        w_smp_prod;
    logic [SAMPLE_W-1:0]       w_smp_mag;

    assign o_sts.will_run = i_start_note | r_active;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign w_len    = (r_note_length < MIN_LENGTH) ? MIN_LENGTH : r_note_length;
    assign w_len_m1 = w_len - 1'b1;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_qbit = (w_rem2 >= {1'b0, r_den});

    assign w_r5_idx = (r_seg == SEG_RELEASE) ?
                      (ENV_IDX_W'(ENV_DEPTH) - {1'b0, r_quo}) : {1'b0, r_quo};

    assign w_coef      = (r_seg == SEG_DECAY) ? DECAY_DEPTH_Q15 : SUSTAIN_COEF;
    assign w_env_prod  = w_coef * r_r5;
    assign w_gain_prod = r_amplitude * r_env;

    assign w_sin_abs  = r_sin[SAMPLE_W-1] ? (SAMPLE_W'(0) - r_sin) : r_sin;
    assign w_smp_prod = r_gain * w_sin_abs[AMP_W-1:0];
    assign w_smp_mag  = {1'b0, w_smp_prod[2*AMP_W-1:AMP_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude   <= AMP_RESET;
            r_note_length <= NOTE_LENGTH_RESET;
            r_active      <= 1'b0;
            r_index       <= '0;
            r_phase       <= '0;
            r_held        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_AMPLITUDE:   r_amplitude   <= i_cfg_data[AMP_W-1:0];
                    CFG_NOTE_LENGTH: r_note_length <= LENGTH_BITS'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_cmd.accept && i_start_note) begin
                r_active <= 1'b1;
                r_index  <= '0;
                r_phase  <= '0;
                r_held   <= i_phase_step;
            end
            if (i_cmd.setup) begin
                r_phase <= r_phase + r_held;
            end
            if (i_cmd.scale) begin
                if (r_last) begin
                    r_active <= 1'b0;
                end else begin
                    r_index <= r_i + 1'b1;
                end
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_len     <= w_len;
            r_i       <= (r_index >= w_len_m1) ? w_len_m1 : r_index;
            r_last    <= (r_index >= w_len_m1);
            r_sin_idx <= r_phase[PHASE_W-1 -: SINE_TABLE_BITS];
        end
        if (i_cmd.scale) begin
            r_i10 <= (I10_W'(r_i) << 3) + (I10_W'(r_i) << 1);
            r_l2  <= I10_W'(r_len) << 1;
            r_l3  <= (I10_W'(r_len) << 1) + I10_W'(r_len);
            r_l8  <= I10_W'(r_len) << 3;
            r_sin <= SINE_ROM[r_sin_idx];
        end
        if (i_cmd.seg) begin
            priority if (r_i10 < r_l3) begin
                r_seg <= SEG_ATTACK;
            end else if (r_i10 < (r_l3 << 1)) begin
                r_seg <= SEG_DECAY;
            end else if (r_i10 < r_l8) begin
                r_seg <= SEG_SUSTAIN;
            end else begin
                r_seg <= SEG_RELEASE;
            end
        end
        if (i_cmd.prep) begin
            r_quo <= '0;
            unique case (r_seg)
                SEG_ATTACK: begin
                    r_rem <= DEN_W'(r_i10);
                    r_den <= DEN_W'(r_l3);
                end
                SEG_DECAY: begin
                    r_rem <= DEN_W'(r_i10 - r_l3);
                    r_den <= DEN_W'(r_l3);
                end
                SEG_SUSTAIN: begin
                    r_rem <= '0;
                    r_den <= DEN_W'(r_l3);
                end
                SEG_RELEASE: begin
                    r_rem <= DEN_W'(r_i10 - r_l8);
                    r_den <= DEN_W'(r_l2);
                end
                default: begin
                    r_rem <= '0;
                    r_den <= DEN_W'(r_l3);
                end
            endcase
        end
        if (i_cmd.div_step) begin
            r_rem <= w_qbit ? DEN_W'(w_rem2 - {1'b0, r_den}) : DEN_W'(w_rem2);
            r_quo <= {r_quo[ENV_TABLE_BITS-2:0], w_qbit};
        end
        if (i_cmd.rom) begin
            r_r10 <= ROOT10_ROM[{1'b0, r_quo}];
            r_r5  <= ROOT5_ROM[w_r5_idx];
        end
        if (i_cmd.env) begin
            unique case (r_seg)
                SEG_ATTACK:  r_env <= r_r10;
                SEG_DECAY:   r_env <= ONE_Q15 - w_env_prod[AMP_W+ENV_W-1:AMP_W];
                SEG_SUSTAIN: r_env <= SUSTAIN_Q15;
                SEG_RELEASE: r_env <= w_env_prod[AMP_W+ENV_W-1:AMP_W];
                default:     r_env <= SUSTAIN_Q15;
            endcase
        end
        if (i_cmd.gain) begin
            r_gain <= w_gain_prod[AMP_W+ENV_W-2:AMP_W];
        end
        if (i_cmd.mul) begin
            r_smp <= r_sin[SAMPLE_W-1] ? signed'(SAMPLE_W'(0) - w_smp_mag)
                                       : signed'(w_smp_mag);
        end
        if (i_cmd.load) begin
            r_out_sample <= r_smp;
            r_out_seg    <= r_seg;
            r_out_last   <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;
    assign o_segment   = r_out_seg;
    assign o_last      = r_out_last;

endmodule

// ----- rtl/adsr_sine_tone_generator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR sine tone generator
// One enveloped sine sample per request while a note plays.
//
//   Channel  Direction  Handshake                 Payload
//   cfg      in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//   in       in         i_in_valid/o_in_stall     i_start_note, i_phase_step
//   out      out        o_out_valid/i_out_stall   o_sample, o_segment, o_last
//
// A request that yields a sample passes through the bit-serial segment
// divider, one quotient bit per cycle.
// A request with no note playing and no start is taken without leaving idle.
// Reset is synchronous; all tables are constant, no clearing pass.
// A stalled result waits in the output register; the next request is held
// off until a request finishes, also while its sample cannot be loaded there.
// ----------------------------------------------------------------------------
module adsr_sine_tone_generator_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [astg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [astg_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_start_note,
    input  logic [astg_pkg::PHASE_W-1:0]          i_phase_step,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [astg_pkg::SAMPLE_W-1:0]  o_sample,
    output logic [astg_pkg::SEG_W-1:0]            o_segment,
    output logic                                  o_last
);
    import astg_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    astg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    astg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid & o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_start_note (i_start_note),
        .i_phase_step (i_phase_step),
        .i_out_stall  (i_out_stall),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (o_out_valid),
        .o_sample     (o_sample),
        .o_segment    (o_segment),
        .o_last       (o_last)
    );

endmodule
